[hdl/lep_pkg.sv]
`timescale 1ns / 1ps

package lep_pkg;

	// Field widths of the payload structs.
	localparam int VALUE_W = 48;
	localparam int TIME_W  = 32;

	// Slope format: signed, 64 bits, 32 fraction bits.
	localparam int SLOPE_W    = 64;
	localparam int SLOPE_FRAC = 32;

	// Request codes.
	localparam logic REQ_STORE   = 1'b0;
	localparam logic REQ_PREDICT = 1'b1;

	// Store count at which slopes start being tracked; the count saturates here.
	localparam logic [2:0] UPD_FULL = 3'd4;

	typedef struct packed {
		logic                      req_type;
		logic signed [VALUE_W-1:0] sample_value;
		logic        [TIME_W-1:0]  time_interval;
	} lep_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] predicted_value;
		logic                      ready_res;
	} lep_out_t;

endpackage

[hdl/linear_extrapolation_predictor_core.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// -------  ---------  --------------------  ----------------------------------------
// in       input      in_valid / in_ready   lep_in_t  (req_type, sample, interval)
// out      output     out_valid / out_ready lep_out_t (predicted_value, ready_res)
//
// A store before the fourth one leaves the sequencer idle. From the fourth store on, a store
// runs two restoring divisions through the shared 65-bit adder, one quotient bit per
// cycle. A prediction runs a shift-and-add multiply on the same adder and then waits
// until the output register is free to take the result.
// in_ready is high only while the sequencer is idle. Asynchronous reset clears all
// stored samples, intervals, the mean slope and the store count. A result held in the
// output register does not stop the next input transfer.
module linear_extrapolation_predictor_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lep_pkg::lep_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lep_pkg::lep_out_t out_data
);

	import lep_pkg::*;

	localparam int PSHIFT = SLOPE_FRAC - FRAC_BITS;
	localparam int NW     = VALUE_W + 1 + PSHIFT;
	localparam int QW     = (NW > SLOPE_W) ? NW : SLOPE_W;
	localparam int PW     = SLOPE_W + TIME_W;
	localparam int SW     = PW - PSHIFT;
	localparam int EW     = (SW > VALUE_W + 1) ? SW : VALUE_W + 1;
	localparam int AW     = SLOPE_W + 1;
	localparam int MAXIT  = (NW > TIME_W) ? NW : TIME_W;
	localparam int ITW    = $clog2(MAXIT);

	localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MAX   = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN   = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIFF = 4'd1;
	localparam logic [3:0] ST_ABS  = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_SAT  = 4'd4;
	localparam logic [3:0] ST_MEAN = 4'd5;
	localparam logic [3:0] ST_MABS = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0]         state_q;
	logic [ITW-1:0]     iter_q;
	logic [2:0]         upd_q;
	logic [VALUE_W-1:0] samp_q [3];
	logic [TIME_W-1:0]  iv_q [2];
	logic [SLOPE_W-1:0] mean_q;
	logic               out_valid_q;
	lep_out_t           out_q;

	logic               k_q;
	logic               neg_q;
	logic               msign_q;
	logic [AW-1:0]      work_q;
	logic [AW-1:0]      slope0_q;
	logic [NW-1:0]      num_q;
	logic [TIME_W-1:0]  rem_q;
	logic [SLOPE_W-1:0] mag_q;
	logic [PW-1:0]      prod_q;

	logic               in_xfer;
	logic [VALUE_W-1:0] newer;
	logic [VALUE_W-1:0] older;
	logic [TIME_W-1:0]  dv;
	logic [TIME_W:0]    trial;
	logic [QW-1:0]      q_ext;
	logic [SLOPE_W-1:0] q_sat;
	logic [AW-1:0]      op_a;
	logic [AW-1:0]      op_b;
	logic               op_sub;
	logic [AW-1:0]      res;
	logic [EW-1:0]      step_ext;
	logic [VALUE_W:0]   step_c;
	logic [VALUE_W+1:0] step_s;
	logic [VALUE_W+1:0] total;
	logic               ovf;
	logic [VALUE_W-1:0] pred;
	logic               out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign newer = k_q ? samp_q[1] : samp_q[0];
	assign older = k_q ? samp_q[2] : samp_q[1];
	assign dv    = (iv_q[k_q] == '0) ? TIME_W'(1) : iv_q[k_q];
	assign trial = {rem_q, num_q[NW-1]};

	// Quotient magnitude clipped to the largest positive slope.
	assign q_ext = QW'(num_q);
	assign q_sat = (|q_ext[QW-1:SLOPE_W-1]) ? SLOPE_MAX : {1'b0, q_ext[SLOPE_W-2:0]};

	// The shared adder: every arithmetic step of the sequencer but the final step-and-sample add goes through here.
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			ST_DIFF: begin
				op_a   = {{(AW-VALUE_W){newer[VALUE_W-1]}}, newer};
				op_b   = {{(AW-VALUE_W){older[VALUE_W-1]}}, older};
				op_sub = 1'b1;
			end
			ST_ABS: begin
				op_b   = work_q;
				op_sub = work_q[AW-1];
			end
			ST_DIV: begin
				op_a   = AW'(trial);
				op_b   = AW'(dv);
				op_sub = 1'b1;
			end
			ST_SAT: begin
				op_b   = AW'(q_sat);
				op_sub = neg_q;
			end
			ST_MEAN: begin
				op_a = slope0_q;
				op_b = work_q;
			end
			ST_MABS: begin
				op_b   = {mean_q[SLOPE_W-1], mean_q};
				op_sub = mean_q[SLOPE_W-1];
			end
			ST_MUL: begin
				op_a = {1'b0, prod_q[PW-1:TIME_W]};
				op_b = {1'b0, mag_q};
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign res = op_a + (op_b ^ {AW{op_sub}}) + AW'(op_sub);

	// A step of 2^VALUE_W or more saturates whatever the last sample is, so the
	// magnitude is clipped there before the final add.
	assign step_ext = EW'(prod_q >> PSHIFT);
	assign step_c   = (|step_ext[EW-1:VALUE_W]) ? {1'b1, {VALUE_W{1'b0}}} : step_ext[VALUE_W:0];
	assign step_s   = msign_q ? -{1'b0, step_c} : {1'b0, step_c};
	assign total    = {{2{samp_q[0][VALUE_W-1]}}, samp_q[0]} + step_s;
	assign ovf      = !((total[VALUE_W+1] == total[VALUE_W]) &&
		(total[VALUE_W] == total[VALUE_W-1]));
	assign pred     = ovf ? (total[VALUE_W+1] ? VAL_MIN : VAL_MAX) : total[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			upd_q       <= '0;
			samp_q[0]   <= '0;
			samp_q[1]   <= '0;
			samp_q[2]   <= '0;
			iv_q[0]     <= '0;
			iv_q[1]     <= '0;
			mean_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_data.req_type == REQ_STORE) begin
							samp_q[2] <= samp_q[1];
							samp_q[1] <= samp_q[0];
							samp_q[0] <= in_data.sample_value;
							iv_q[1]   <= iv_q[0];
							iv_q[0]   <= in_data.time_interval;
							if (upd_q != UPD_FULL) begin
								upd_q <= upd_q + 3'd1;
							end
							if (upd_q >= UPD_FULL - 3'd1) begin
								state_q <= ST_DIFF;
							end
						end else begin
							state_q <= ST_MABS;
						end
					end
				end
				ST_DIFF: begin
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					iter_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (iter_q == ITW'(NW - 1)) begin
						state_q <= ST_SAT;
					end else begin
						iter_q <= iter_q + ITW'(1);
					end
				end
				ST_SAT: begin
					state_q <= k_q ? ST_MEAN : ST_DIFF;
				end
				ST_MEAN: begin
					mean_q  <= res[AW-1:1];
					state_q <= ST_IDLE;
				end
				ST_MABS: begin
					iter_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (iter_q == ITW'(TIME_W - 1)) begin
						state_q <= ST_OUT;
					end else begin
						iter_q <= iter_q + ITW'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Loading a new result takes priority over the transfer of the one it replaces.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				k_q    <= 1'b0;
				prod_q <= PW'(in_data.time_interval);
			end
			ST_DIFF: begin
				work_q <= res;
			end
			ST_ABS: begin
				neg_q <= work_q[AW-1];
				num_q <= NW'(res[VALUE_W:0]) << PSHIFT;
				rem_q <= '0;
			end
			ST_DIV: begin
				// A clear sign bit means the trial remainder covered the divisor.
				if (!res[AW-1]) begin
					rem_q <= res[TIME_W-1:0];
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial[TIME_W-1:0];
					num_q <= {num_q[NW-2:0], 1'b0};
				end
			end
			ST_SAT: begin
				if (!k_q) begin
					slope0_q <= res;
					k_q      <= 1'b1;
				end else begin
					work_q <= res;
				end
			end
			ST_MABS: begin
				msign_q <= mean_q[SLOPE_W-1];
				mag_q   <= res[SLOPE_W-1:0];
			end
			ST_MUL: begin
				if (prod_q[0]) begin
					prod_q <= {res, prod_q[TIME_W-1:1]};
				end else begin
					prod_q <= {1'b0, prod_q[PW-1:1]};
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_q.predicted_value <= pred;
					out_q.ready_res       <= (upd_q == UPD_FULL);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_predict_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.req_type == REQ_PREDICT) |=> (state_q == ST_MABS))
		else $error("predict transfer did not start the multiply sequence");

	a_early_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.req_type == REQ_STORE && upd_q < UPD_FULL - 3'd1)
		|=> (state_q == ST_IDLE))
		else $error("store before the fourth one started a slope update");

	a_div_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (iter_q <= ITW'(NW - 1)))
		else $error("divider iteration count out of range");

	a_out_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid && !out_ready) |=> (state_q == ST_OUT))
		else $error("result left the sequencer while the output register was full");

endmodule
